// ===== rtl/fab_pkg.sv =====
// ----------------------------------------------------------------------------
// fab_pkg
// Shared types and codes for the frame bitmap allocator: request kinds,
// result status codes, register indexes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package fab_pkg;

    // request kinds
    typedef enum logic [1:0] {
        KIND_FREE  = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_FIRST = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ALREADY = 2'd1,
        ST_FULL    = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_POOL_START  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT = 8'd1;

    // commands from controller to datapath
    typedef struct packed {
        logic clear;     // clear one bitmap word
        logic accept;    // latch a new request and its frame index
        logic check;     // apply the range result, read the target word
        logic update;    // read-modify-write of the target word (query only reads its bit)
        logic scan;      // one step of the first-free search
        logic mul;       // frame index times frame size
        logic load_out;  // move the result into the output register
    } fab_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic first_req;
        logic oor;
        logic found;
        logic scan_fail;
    } fab_stat_t;

endpackage

// ===== rtl/frame_bitmap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_top
// First-fit page frame allocator over a one-bit-per-frame bitmap, with
// configuration registers for pool start address and frame count.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------
//  in      | in_valid / in_stall  | kind, frame_address
//  out     | out_valid / out_stall| status, given_address, is_allocated
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  free, named allocate, query: check, update and finish states, no update when out of range;
//  the index is a shift of the offset, FRAME_SIZE being a power of two.
//  first-free: scan, multiply and finish states, one bitmap word a cycle while scanning.
//  after reset a clearing pass over every bitmap word keeps in_stall
//  high; configuration writes are accepted throughout.
//  a new request is taken while a result waits; a stalled result holds the sequencer.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_top
    import fab_pkg::*;
#(
    parameter int unsigned NUM_FRAMES = 1024,
    parameter int unsigned FRAME_SIZE = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             kind,
    input  logic [31:0]            frame_address,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             status,
    output logic [31:0]            given_address,
    output logic                   is_allocated,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    logic [31:0] pool_start_reg;
    logic [10:0] frame_count_reg;
    fab_cmd_t    cmd;
    fab_stat_t   stat;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_start_reg  <= '0;
            frame_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_POOL_START)
            begin
                pool_start_reg <= cfg_data;
            end
            else if (cfg_index == REG_FRAME_COUNT)
            begin
                frame_count_reg <= cfg_data[10:0];
            end
        end
    end

    // sequencer
    fab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    fab_dp #(
        .NUM_FRAMES (NUM_FRAMES),
        .FRAME_SIZE (FRAME_SIZE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .pool_start  (pool_start_reg),
        .frame_count (frame_count_reg),
        .req_kind    (kind),
        .req_address (frame_address),
        .res_status  (status),
        .res_given   (given_address),
        .res_alloc   (is_allocated)
    );

endmodule

// ===== rtl/fab_ctrl.sv =====
// ----------------------------------------------------------------------------
// fab_ctrl
// Sequencer for the allocator: clearing pass after reset, request decode,
// bitmap update or first-free scan, and result hand-off.
// ----------------------------------------------------------------------------
module fab_ctrl
    import fab_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  fab_stat_t stat,
    output fab_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b000_0001,
        S_IDLE   = 7'b000_0010,
        S_CHECK  = 7'b000_0100,
        S_UPDATE = 7'b000_1000,
        S_SCAN   = 7'b001_0000,
        S_MUL    = 7'b010_0000,
        S_FINISH = 7'b100_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.first_req ? S_SCAN : S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.oor ? S_FINISH : S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_FINISH;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.found)
                begin
                    state_next = S_MUL;
                end
                else if (stat.scan_fail)
                begin
                    state_next = S_FINISH;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared once taken
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/fab_dp.sv =====
// ----------------------------------------------------------------------------
// fab_dp
// Datapath of the allocator: bitmap memory, frame index by shift,
// first-free word scan, address scaling and the result register.
// ----------------------------------------------------------------------------
module fab_dp
    import fab_pkg::*;
#(
    parameter int unsigned NUM_FRAMES = 1024,
    parameter int unsigned FRAME_SIZE = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  fab_cmd_t    cmd,
    output fab_stat_t   stat,
    input  logic [31:0] pool_start,
    input  logic [10:0] frame_count,
    input  logic [1:0]  req_kind,
    input  logic [31:0] req_address,
    output logic [1:0]  res_status,
    output logic [31:0] res_given,
    output logic        res_alloc
);

    localparam int unsigned WORDS  = (NUM_FRAMES + 31) / 32;
    localparam int unsigned WW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned FW     = WW + 5;          // frame index width
    localparam int unsigned CW     = FW + 1;          // frame count width
    localparam int unsigned NW     = WW + 2;          // word count width
    localparam int unsigned FSHIFT = $clog2(FRAME_SIZE); // frame size is a power of two

    // bitmap memory
    logic [31:0]   mem [0:WORDS-1];
    logic [31:0]   rd_data_reg;
    logic          rd_en;
    logic [WW-1:0] rd_addr;
    logic          wr_en;
    logic [WW-1:0] wr_addr;
    logic [31:0]   wr_data;

    // request state
    kind_t         kind_reg;
    logic          oor_reg;
    logic [FW-1:0] quo_reg;

    // scan state
    logic [WW-1:0] clr_addr_reg;
    logic [WW:0]   scan_addr_reg;
    logic [WW-1:0] chk_addr_reg;
    logic          chk_valid_reg;
    logic          issue;
    logic          found;

    // result state
    status_t       status_reg;
    logic          alloc_reg;
    logic          give_reg;
    logic [FW-1:0] idx_reg;
    logic [31:0]   prod_reg;
    logic [1:0]    out_status_reg;
    logic [31:0]   out_given_reg;
    logic          out_alloc_reg;

    // derived values
    logic [CW-1:0] pool_frames;
    logic [CW:0]   nwords_sum;
    logic [NW-1:0] nwords;
    logic [WW-1:0] quo_word;
    logic [31:0]   bit_mask;
    logic          word_bit;
    logic [31:0]   valid_mask;
    logic [31:0]   free_bits;
    logic [31:0]   low_onehot;
    logic [4:0]    low_pos;
    logic [32:0]   offset;
    logic [31:0]   quo_full;

    // one-hot to bit position
    function automatic logic [4:0] onehot_pos(input logic [31:0] oh);
        logic [4:0] pos;
        pos = '0;
        for (int j = 0; j < 32; j++)
        begin
            for (int k = 0; k < 5; k++)
            begin
                if (((j >> k) & 1) == 1)
                begin
                    pos[k] = pos[k] | oh[j];
                end
            end
        end
        return pos;
    endfunction

    // pool size capped at the bitmap size
    always_comb
    begin
        if (32'(frame_count) > 32'(NUM_FRAMES))
        begin
            pool_frames = CW'(NUM_FRAMES);
        end
        else
        begin
            pool_frames = CW'(frame_count);
        end
    end

    assign nwords_sum = (CW+1)'(pool_frames) + (CW+1)'(31);
    assign nwords     = nwords_sum[CW:5];
    assign offset     = {1'b0, req_address} - {1'b0, pool_start};

    // frame index of the requested address
    assign quo_full = offset[31:0] >> FSHIFT;

    // named-frame access
    assign quo_word = quo_reg[FW-1:5];
    assign bit_mask = 32'd1 << quo_reg[4:0];
    assign word_bit = rd_data_reg[quo_reg[4:0]];

    // first-free search on the word just read
    assign valid_mask = ({1'b0, chk_addr_reg} == pool_frames[CW-1:5])
                      ? ((32'd1 << pool_frames[4:0]) - 32'd1) : '1;
    assign free_bits  = ~rd_data_reg & valid_mask;
    assign low_onehot = free_bits & (~free_bits + 32'd1);
    assign low_pos    = onehot_pos(low_onehot);
    assign found      = cmd.scan && chk_valid_reg && (free_bits != '0);
    assign issue      = cmd.scan && !found && ({1'b0, scan_addr_reg} < nwords);

    // status to controller
    assign stat.clear_last = (clr_addr_reg == WW'(WORDS - 1));
    assign stat.first_req  = (kind_t'(req_kind) == KIND_FIRST);
    assign stat.oor        = oor_reg;
    assign stat.found      = found;
    assign stat.scan_fail  = cmd.scan && !chk_valid_reg && !issue;

    // memory port selection
    assign rd_en   = cmd.check || issue;
    assign rd_addr = cmd.scan ? scan_addr_reg[WW-1:0] : quo_word;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_addr_reg;
        wr_data = '0;
        if (cmd.clear)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.update)
        begin
            wr_addr = quo_word;
            case (kind_reg)
                KIND_FREE:
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_reg & ~bit_mask;
                end
                KIND_ALLOC:
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_reg | bit_mask;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        else if (found)
        begin
            wr_en   = 1'b1;
            wr_addr = chk_addr_reg;
            wr_data = rd_data_reg | low_onehot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + WW'(1);
            end
            if (cmd.accept)
            begin
                chk_valid_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                chk_valid_reg <= issue;
            end
        end
    end

    // request, scan and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg      <= kind_t'(req_kind);
            oor_reg       <= offset[32] || (quo_full >= 32'(pool_frames));
            quo_reg       <= quo_full[FW-1:0];
            scan_addr_reg <= '0;
            status_reg    <= ST_OK;
            alloc_reg     <= 1'b0;
            give_reg      <= 1'b0;
        end
        if (cmd.check && stat.oor)
        begin
            status_reg <= ST_RANGE;
        end
        if (cmd.update)
        begin
            if (kind_reg == KIND_ALLOC && word_bit)
            begin
                status_reg <= ST_ALREADY;
            end
            if (kind_reg == KIND_QUERY)
            begin
                alloc_reg <= word_bit;
            end
        end
        if (issue)
        begin
            chk_addr_reg  <= scan_addr_reg[WW-1:0];
            scan_addr_reg <= scan_addr_reg + (WW+1)'(1);
        end
        if (found)
        begin
            idx_reg  <= {chk_addr_reg, low_pos};
            give_reg <= 1'b1;
        end
        if (stat.scan_fail)
        begin
            status_reg <= ST_FULL;
        end
        if (cmd.mul)
        begin
            prod_reg <= 32'(idx_reg) << FSHIFT;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_given_reg  <= give_reg ? (pool_start + prod_reg) : '0;
            out_alloc_reg  <= alloc_reg;
        end
    end

    assign res_status = out_status_reg;
    assign res_given  = out_given_reg;
    assign res_alloc  = out_alloc_reg;

endmodule
